// File: rtl/avcd_pkg.sv
// avcd_pkg: shared types and constants of the avi video chunk demultiplexer
package avcd_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_AVI  = 32'h2049_5641;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [31:0] TAG_HDRL = 32'h6C72_6468;
    localparam logic [31:0] TAG_AVIH = 32'h6869_7661;
    localparam logic [31:0] TAG_MOVI = 32'h6976_6F6D;
    localparam logic [31:0] TAG_00DC = 32'h6364_3030;
    localparam logic [31:0] TAG_00DB = 32'h6264_3030;

    localparam logic [22:0] FALLBACK_MS  = 23'd100;
    localparam logic [31:0] AVIH_READ_MAX = 32'd40;
    // floor(x / 1000) = (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
    localparam logic [31:0] DIV1000_MAGIC = 32'h8312_6E98;
    localparam int          DIV1000_SHIFT = 41;
    localparam logic [23:0] CAPACITY_RESET = 24'd131072;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_RIFF_HDR  = 4'd0,
        PH_RIFF_TYPE = 4'd1,
        PH_TOP_HDR   = 4'd2,
        PH_LIST_TYPE = 4'd3,
        PH_HDRL_HDR  = 4'd4,
        PH_AVIH      = 4'd5,
        PH_SKIP_TOP  = 4'd6,
        PH_SKIP_HDRL = 4'd7,
        PH_MOVI_HDR  = 4'd8,
        PH_FRAME     = 4'd9,
        PH_SKIP_MOVI = 4'd10,
        PH_DONE      = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_INFO    = 2'd1,
        KIND_STATUS  = 2'd2,
        KIND_EMPTY   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_NOT_RIFF  = 3'd0,
        ST_NOT_AVI   = 3'd1,
        ST_NO_MOVI   = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_MOVI_END  = 3'd5
    } status_t;

    typedef struct packed {
        logic [22:0] interval_ms;
        logic [31:0] frame_count;
        logic [31:0] frame_height;
        logic [31:0] frame_width;
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [1:0]  kind;
    } result_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] s;
        s = {2'b00, a} + {1'b0, b};
        sat_add = (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: rtl/avi_video_chunk_demux.sv
// avi_video_chunk_demux: byte-serial avi container parser emitting frame bytes, stream info and status
// a result is written into the output queue at the edge that takes its byte and is presented
// from the queue registers; throughput is one byte per cycle while the queue has room, set by the
// one-pass parser between the state registers and a four-entry result queue
// a byte that gives two results needs two queue slots, so input stalls at three or more held
// reset clears parse state, queue and capacity (131072) asynchronously
module avi_video_chunk_demux
    import avcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // start_of_file
    input  logic         s_tlast,   // end_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // payload_byte, status, frame_width, frame_height,
                                    // frame_count, interval_ms, zero fill
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,   // frame_last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data   // frame_capacity
);

    phase_t       ph_reg, ph_next;
    logic [31:0]  off_reg, off_next;
    logic [63:0]  hs_reg, hs_next;
    logic [3:0]   hc_reg, hc_next;
    logic [32:0]  skip_reg, skip_next;
    logic [31:0]  lend_reg, lend_next;
    logic [31:0]  mend_reg, mend_next;
    logic [31:0]  fld_reg [4];
    logic [31:0]  fld_next [4];
    logic         seen_reg, seen_next;
    logic [23:0]  cap_reg;
    logic [63:0]  prod_reg;

    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [FIFO_AW:0]     cnt_reg;

    result_t     res [2];
    logic [1:0]  nres;
    logic [22:0] ms;
    logic        in_acc, out_acc;

    assign s_tready  = (cnt_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != '0);
    assign out_acc   = m_tvalid && m_tready;

    assign m_tuser = fifo_mem[rp_reg].kind;
    assign m_tlast = fifo_mem[rp_reg].frame_last;
    assign m_tdata = {6'd0, fifo_mem[rp_reg].interval_ms, fifo_mem[rp_reg].frame_count,
                      fifo_mem[rp_reg].frame_height, fifo_mem[rp_reg].frame_width,
                      fifo_mem[rp_reg].status, fifo_mem[rp_reg].payload_byte};

    always_comb
    begin
        logic [22:0] q;
        q  = prod_reg[DIV1000_SHIFT +: 23];
        ms = (seen_reg && q != '0) ? q : FALLBACK_MS;
    end

    always_comb
    begin
        logic [31:0] tag, size, k, tgt, w;
        logic [32:0] pay, n33;
        logic [33:0] sum;
        logic        bnd_hdrl, bnd_movi, emit_last;
        result_t     r;
        tag = '0; size = '0; k = '0; tgt = '0; w = '0; pay = '0; n33 = '0; sum = '0;
        bnd_hdrl = 1'b0; bnd_movi = 1'b0; emit_last = 1'b0;
        r = '0;
        res[0] = '0;
        res[1] = '0;
        nres = 2'd0;

        ph_next   = ph_reg;
        off_next  = off_reg;
        hs_next   = hs_reg;
        hc_next   = hc_reg;
        skip_next = skip_reg;
        lend_next = lend_reg;
        mend_next = mend_reg;
        fld_next  = fld_reg;
        seen_next = seen_reg;

        if (s_tuser)
        begin
            ph_next   = PH_RIFF_HDR;
            off_next  = '0;
            hs_next   = '0;
            hc_next   = '0;
            skip_next = '0;
            lend_next = '0;
            mend_next = '0;
            fld_next  = '{default: '0};
            seen_next = 1'b0;
        end

        if (ph_next != PH_DONE)
        begin
            off_next = sat_add(off_next, 33'd1);
            case (ph_next)
                PH_SKIP_TOP, PH_SKIP_HDRL, PH_SKIP_MOVI:
                begin
                    skip_next = skip_next - 33'd1;
                    if (skip_next == '0)
                    begin
                        if (ph_next == PH_SKIP_TOP)
                        begin
                            hs_next = '0;
                            hc_next = '0;
                            ph_next = PH_TOP_HDR;
                        end
                        else if (ph_next == PH_SKIP_HDRL)
                            bnd_hdrl = 1'b1;
                        else
                            bnd_movi = 1'b1;
                    end
                end
                PH_AVIH:
                begin
                    size = hs_next[31:0];
                    n33  = {1'b0, size} + {32'd0, size[0]} - skip_next;
                    k    = n33[31:0];
                    if (k < size && k < AVIH_READ_MAX)
                    begin
                        w = k >> 2;
                        if (w == 32'd0)
                            fld_next[0] = fld_next[0] | ({24'd0, s_tdata} << {k[1:0], 3'b000});
                        else if (w == 32'd4)
                            fld_next[1] = fld_next[1] | ({24'd0, s_tdata} << {k[1:0], 3'b000});
                        else if (w == 32'd8)
                            fld_next[2] = fld_next[2] | ({24'd0, s_tdata} << {k[1:0], 3'b000});
                        else if (w == 32'd9)
                            fld_next[3] = fld_next[3] | ({24'd0, s_tdata} << {k[1:0], 3'b000});
                    end
                    skip_next = skip_next - 33'd1;
                    if (skip_next == '0)
                        bnd_hdrl = 1'b1;
                end
                PH_FRAME:
                begin
                    skip_next = skip_next - 33'd1;
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = s_tdata;
                    if (skip_next == '0)
                    begin
                        r.frame_last = 1'b1;
                        if (hs_next[0])
                        begin
                            skip_next = 33'd1;
                            ph_next   = PH_SKIP_MOVI;
                        end
                        else
                            bnd_movi = 1'b1;
                    end
                    res[0] = r;
                    nres = 2'd1;
                end
                default:
                begin
                    hs_next = {s_tdata, hs_next[63:8]};
                    hc_next = hc_next + 4'd1;
                    size    = hs_next[63:32];
                    tag     = (hc_next == 4'd8) ? hs_next[31:0] : hs_next[63:32];
                    if (ph_next == PH_RIFF_HDR && hc_next == 4'd8)
                    begin
                        if (tag != TAG_RIFF)
                        begin
                            r = '0;
                            r.kind = KIND_STATUS;
                            r.status = ST_NOT_RIFF;
                            res[0] = r;
                            nres = 2'd1;
                            ph_next = PH_DONE;
                        end
                        else
                        begin
                            hs_next = '0;
                            hc_next = '0;
                            ph_next = PH_RIFF_TYPE;
                        end
                    end
                    else if (ph_next == PH_RIFF_TYPE && hc_next == 4'd4)
                    begin
                        if (tag != TAG_AVI)
                        begin
                            r = '0;
                            r.kind = KIND_STATUS;
                            r.status = ST_NOT_AVI;
                            res[0] = r;
                            nres = 2'd1;
                            ph_next = PH_DONE;
                        end
                        else
                        begin
                            hs_next = '0;
                            hc_next = '0;
                            ph_next = PH_TOP_HDR;
                        end
                    end
                    else if (ph_next == PH_TOP_HDR && hc_next == 4'd8)
                    begin
                        hs_next = '0;
                        hc_next = '0;
                        if (tag == TAG_LIST)
                        begin
                            skip_next = {1'b0, size};
                            ph_next   = PH_LIST_TYPE;
                        end
                        else
                        begin
                            skip_next = {1'b0, size} + {32'd0, size[0]};
                            ph_next   = (skip_next == '0) ? PH_TOP_HDR : PH_SKIP_TOP;
                        end
                    end
                    else if (ph_next == PH_LIST_TYPE && hc_next == 4'd4)
                    begin
                        pay = (skip_next >= 33'd4) ? skip_next - 33'd4 : '0;
                        hs_next = '0;
                        hc_next = '0;
                        if (tag == TAG_HDRL)
                        begin
                            lend_next = sat_add(off_next, pay);
                            bnd_hdrl  = 1'b1;
                        end
                        else if (tag == TAG_MOVI)
                        begin
                            mend_next = sat_add(off_next, pay);
                            r = '0;
                            r.kind = KIND_INFO;
                            r.frame_width  = fld_reg[2];
                            r.frame_height = fld_reg[3];
                            r.frame_count  = fld_reg[1];
                            r.interval_ms  = ms;
                            res[0] = r;
                            nres = 2'd1;
                            bnd_movi = 1'b1;
                        end
                        else
                        begin
                            skip_next = pay + {32'd0, pay[0]};
                            ph_next   = (skip_next == '0) ? PH_TOP_HDR : PH_SKIP_TOP;
                        end
                    end
                    else if (ph_next == PH_HDRL_HDR && hc_next == 4'd8)
                    begin
                        skip_next = {1'b0, size} + {32'd0, size[0]};
                        if (tag == TAG_AVIH)
                        begin
                            fld_next  = '{default: '0};
                            seen_next = 1'b1;
                            hs_next   = {32'd0, size};
                            hc_next   = '0;
                            if (skip_next == '0)
                                bnd_hdrl = 1'b1;
                            else
                                ph_next = PH_AVIH;
                        end
                        else if (skip_next == '0)
                            bnd_hdrl = 1'b1;
                        else
                            ph_next = PH_SKIP_HDRL;
                    end
                    else if (ph_next == PH_MOVI_HDR && hc_next == 4'd8)
                    begin
                        skip_next = {1'b0, size} + {32'd0, size[0]};
                        if ((tag == TAG_00DC || tag == TAG_00DB) && size > {8'd0, cap_reg})
                        begin
                            r = '0;
                            r.kind = KIND_STATUS;
                            r.status = ST_TOO_LARGE;
                            res[0] = r;
                            nres = 2'd1;
                            if (skip_next == '0)
                                bnd_movi = 1'b1;
                            else
                                ph_next = PH_SKIP_MOVI;
                        end
                        else if ((tag == TAG_00DC || tag == TAG_00DB) && size == '0)
                        begin
                            r = '0;
                            r.kind = KIND_EMPTY;
                            res[0] = r;
                            nres = 2'd1;
                            bnd_movi = 1'b1;
                        end
                        else if (tag == TAG_00DC || tag == TAG_00DB)
                        begin
                            hs_next   = {32'd0, size};
                            hc_next   = '0;
                            skip_next = {1'b0, size};
                            ph_next   = PH_FRAME;
                        end
                        else if (skip_next == '0)
                            bnd_movi = 1'b1;
                        else
                            ph_next = PH_SKIP_MOVI;
                    end
                end
            endcase

            if (bnd_hdrl)
            begin
                hs_next = '0;
                hc_next = '0;
                if (off_next < lend_next)
                    ph_next = PH_HDRL_HDR;
                else
                begin
                    tgt = sat_add(lend_next, {32'd0, lend_next[0]});
                    if (tgt > off_next)
                    begin
                        skip_next = {1'b0, tgt - off_next};
                        ph_next   = PH_SKIP_TOP;
                    end
                    else
                        ph_next = PH_TOP_HDR;
                end
            end

            if (bnd_movi)
            begin
                hs_next = '0;
                hc_next = '0;
                if (off_next >= mend_next)
                begin
                    ph_next = PH_DONE;
                    emit_last = 1'b1;
                end
                else
                    ph_next = PH_MOVI_HDR;
            end

            if (emit_last)
            begin
                r = '0;
                r.kind = KIND_STATUS;
                r.status = ST_MOVI_END;
                res[nres[0]] = r;
                nres = nres + 2'd1;
            end

            if (s_tlast && ph_next != PH_DONE)
            begin
                r = '0;
                r.kind = KIND_STATUS;
                sum = {2'b00, off_next} + {1'b0, skip_next};
                case (ph_next)
                    PH_RIFF_HDR:  r.status = ST_NOT_RIFF;
                    PH_RIFF_TYPE: r.status = ST_NOT_AVI;
                    PH_SKIP_MOVI: r.status = (sum >= {2'b00, mend_next}) ? ST_MOVI_END
                                                                         : ST_TRUNCATED;
                    PH_MOVI_HDR,
                    PH_FRAME:     r.status = ST_TRUNCATED;
                    default:      r.status = ST_NO_MOVI;
                endcase
                res[nres[0]] = r;
                nres = nres + 2'd1;
                ph_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_RIFF_HDR;
            off_reg  <= '0;
            hs_reg   <= '0;
            hc_reg   <= '0;
            skip_reg <= '0;
            lend_reg <= '0;
            mend_reg <= '0;
            fld_reg  <= '{default: '0};
            seen_reg <= 1'b0;
            cap_reg  <= CAPACITY_RESET;
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (in_acc)
            begin
                ph_reg   <= ph_next;
                off_reg  <= off_next;
                hs_reg   <= hs_next;
                hc_reg   <= hc_next;
                skip_reg <= skip_next;
                lend_reg <= lend_next;
                mend_reg <= mend_next;
                fld_reg  <= fld_next;
                seen_reg <= seen_next;
                wp_reg   <= wp_reg + FIFO_AW'(nres);
            end
            if (out_acc)
                rp_reg <= rp_reg + FIFO_AW'(1);
            cnt_reg <= cnt_reg + (in_acc ? (FIFO_AW + 1)'(nres) : '0)
                               - (out_acc ? (FIFO_AW + 1)'(1) : '0);
        end
    end

    // queue storage and divide-by-1000 product
    always_ff @(posedge clk)
    begin
        prod_reg <= fld_reg[0] * DIV1000_MAGIC;
        if (in_acc && nres != 2'd0)
            fifo_mem[wp_reg] <= res[0];
        if (in_acc && nres == 2'd2)
            fifo_mem[wp_reg + FIFO_AW'(1)] <= res[1];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_PAYLOAD))
        else $error("frame_last on a non-payload result");

    a_info_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_INFO) |-> (m_tdata[129:107] != '0))
        else $error("stream info with zero interval");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ph_reg == PH_DONE && !s_tuser) |-> (nres == 2'd0))
        else $error("result emitted after parse end");

endmodule

// File: bench/tb_avi_video_chunk_demux.sv
// testbench for the avi video chunk demultiplexer: random avi files against a parser model
`timescale 1ns / 100ps

module tb_avi_video_chunk_demux;
    import avcd_pkg::*;

    typedef bit [7:0] byte_q_t[$];

    typedef struct {
        kind_t       kind;
        logic [7:0]  pbyte;
        logic        last;
        logic [2:0]  st;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] count;
        logic [22:0] ms;
    } demux_res_t;

    class demux_scoreboard;
        demux_res_t  want_q[$];
        int          errors;
        logic [23:0] capacity;
        phase_t      phase;
        logic [31:0] offset;
        logic [63:0] hshift;
        logic [3:0]  hcount;
        logic [63:0] remain;
        logic [31:0] list_end;
        logic [31:0] movi_end;
        logic [31:0] hdr_field[4];
        bit          hdr_seen;

        function new();
            capacity = CAPACITY_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_RIFF_HDR;
            offset = 0;
            hshift = 0;
            hcount = 0;
            remain = 0;
            list_end = 0;
            movi_end = 0;
            foreach (hdr_field[i]) hdr_field[i] = 0;
            hdr_seen = 0;
        endfunction

        function logic [31:0] clamp_add(logic [31:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {33'b0, a} + {1'b0, b};
            return (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void emit(kind_t k, logic [7:0] b, logic l, logic [2:0] s);
            demux_res_t r;
            logic [31:0] q;
            r = '{k, b, l, s, '0, '0, '0, '0};
            if (k == KIND_INFO)
            begin
                q = hdr_seen ? hdr_field[0] / 1000 : 100;
                if (q == 0)
                    q = 100;
                r.width = hdr_field[2];
                r.height = hdr_field[3];
                r.count = hdr_field[1];
                r.ms = q[22:0];
            end
            want_q.push_back(r);
        endfunction

        function void to_top();
            hshift = 0;
            hcount = 0;
            phase = PH_TOP_HDR;
        endfunction

        function void skip_top(logic [63:0] n);
            if (n == 0)
                to_top();
            else
            begin
                remain = n;
                phase = PH_SKIP_TOP;
            end
        endfunction

        function void hdrl_edge();
            logic [31:0] t;
            hshift = 0;
            hcount = 0;
            if (offset < list_end)
                phase = PH_HDRL_HDR;
            else
            begin
                t = clamp_add(list_end, 64'(list_end[0]));
                skip_top(t > offset ? 64'(t - offset) : 64'd0);
            end
        endfunction

        function void movi_edge();
            hshift = 0;
            hcount = 0;
            if (offset >= movi_end)
            begin
                phase = PH_DONE;
                emit(KIND_STATUS, 0, 0, ST_MOVI_END);
            end
            else
                phase = PH_MOVI_HDR;
        endfunction

        function void skip_movi(logic [63:0] n);
            if (n == 0)
                movi_edge();
            else
            begin
                remain = n;
                phase = PH_SKIP_MOVI;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic sof, logic eof);
            logic [31:0] tag, size, k, w;
            logic [63:0] pay;
            int idx;
            if (sof)
                restart();
            if (phase == PH_DONE)
                return;
            offset = clamp_add(offset, 64'd1);
            case (phase)
                PH_SKIP_TOP, PH_SKIP_HDRL, PH_SKIP_MOVI:
                begin
                    remain--;
                    if (remain == 0)
                    begin
                        if (phase == PH_SKIP_TOP)
                            to_top();
                        else if (phase == PH_SKIP_HDRL)
                            hdrl_edge();
                        else
                            movi_edge();
                    end
                end
                PH_AVIH:
                begin
                    size = hshift[31:0];
                    k = size + size[0] - remain[31:0];
                    if (k < size && k < 40)
                    begin
                        w = k >> 2;
                        idx = (w == 0) ? 0 : (w == 4) ? 1 : (w == 8) ? 2 : (w == 9) ? 3 : 4;
                        if (idx < 4)
                            hdr_field[idx] |= {24'b0, b} << (k[1:0] * 8);
                    end
                    remain--;
                    if (remain == 0)
                        hdrl_edge();
                end
                PH_FRAME:
                begin
                    remain--;
                    if (remain == 0)
                    begin
                        emit(KIND_PAYLOAD, b, 1, 0);
                        if (hshift[0])
                            skip_movi(64'd1);
                        else
                            movi_edge();
                    end
                    else
                        emit(KIND_PAYLOAD, b, 0, 0);
                end
                default:
                begin
                    hshift = {b, hshift[63:8]};
                    hcount++;
                    tag = hshift[63:32];
                    size = tag;
                    if (hcount == 8)
                        tag = hshift[31:0];
                    if (phase == PH_RIFF_HDR && hcount == 8)
                    begin
                        if (tag != TAG_RIFF)
                        begin
                            emit(KIND_STATUS, 0, 0, ST_NOT_RIFF);
                            phase = PH_DONE;
                        end
                        else
                        begin
                            hshift = 0;
                            hcount = 0;
                            phase = PH_RIFF_TYPE;
                        end
                    end
                    else if (phase == PH_RIFF_TYPE && hcount == 4)
                    begin
                        if (tag != TAG_AVI)
                        begin
                            emit(KIND_STATUS, 0, 0, ST_NOT_AVI);
                            phase = PH_DONE;
                        end
                        else
                            to_top();
                    end
                    else if (phase == PH_TOP_HDR && hcount == 8)
                    begin
                        if (tag == TAG_LIST)
                        begin
                            remain = 64'(size);
                            hshift = 0;
                            hcount = 0;
                            phase = PH_LIST_TYPE;
                        end
                        else
                            skip_top(64'(size) + size[0]);
                    end
                    else if (phase == PH_LIST_TYPE && hcount == 4)
                    begin
                        pay = remain >= 4 ? remain - 4 : 0;
                        if (tag == TAG_HDRL)
                        begin
                            list_end = clamp_add(offset, pay);
                            hdrl_edge();
                        end
                        else if (tag == TAG_MOVI)
                        begin
                            movi_end = clamp_add(offset, pay);
                            emit(KIND_INFO, 0, 0, 0);
                            movi_edge();
                        end
                        else
                            skip_top(pay + pay[0]);
                    end
                    else if (phase == PH_HDRL_HDR && hcount == 8)
                    begin
                        if (tag == TAG_AVIH)
                        begin
                            foreach (hdr_field[i]) hdr_field[i] = 0;
                            hdr_seen = 1;
                            hshift = 64'(size);
                            hcount = 0;
                            remain = 64'(size) + size[0];
                            if (remain == 0)
                                hdrl_edge();
                            else
                                phase = PH_AVIH;
                        end
                        else if (64'(size) + size[0] == 0)
                            hdrl_edge();
                        else
                        begin
                            remain = 64'(size) + size[0];
                            phase = PH_SKIP_HDRL;
                        end
                    end
                    else if (phase == PH_MOVI_HDR && hcount == 8)
                    begin
                        if (tag == TAG_00DC || tag == TAG_00DB)
                        begin
                            if (size > {8'b0, capacity})
                            begin
                                emit(KIND_STATUS, 0, 0, ST_TOO_LARGE);
                                skip_movi(64'(size) + size[0]);
                            end
                            else if (size == 0)
                            begin
                                emit(KIND_EMPTY, 0, 0, 0);
                                movi_edge();
                            end
                            else
                            begin
                                hshift = 64'(size);
                                hcount = 0;
                                remain = 64'(size);
                                phase = PH_FRAME;
                            end
                        end
                        else
                            skip_movi(64'(size) + size[0]);
                    end
                end
            endcase
            if (eof && phase != PH_DONE)
            begin
                if (phase == PH_RIFF_HDR)
                    emit(KIND_STATUS, 0, 0, ST_NOT_RIFF);
                else if (phase == PH_RIFF_TYPE)
                    emit(KIND_STATUS, 0, 0, ST_NOT_AVI);
                else if (phase == PH_SKIP_MOVI)
                    emit(KIND_STATUS, 0, 0,
                         (64'(offset) + remain >= 64'(movi_end)) ? ST_MOVI_END : ST_TRUNCATED);
                else if (phase == PH_MOVI_HDR || phase == PH_FRAME)
                    emit(KIND_STATUS, 0, 0, ST_TRUNCATED);
                else
                    emit(KIND_STATUS, 0, 0, ST_NO_MOVI);
                phase = PH_DONE;
            end
        endfunction

        function void check_result(demux_res_t got);
            demux_res_t w;
            if (want_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d byte %h", $time, got.kind, got.pbyte);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (w.kind !== got.kind)
                begin $display("%0t: kind exp %0d got %0d", $time, w.kind, got.kind); errors++; end
            if (w.pbyte !== got.pbyte)
                begin $display("%0t: byte exp %h got %h", $time, w.pbyte, got.pbyte); errors++; end
            if (w.last !== got.last)
                begin $display("%0t: last exp %b got %b", $time, w.last, got.last); errors++; end
            if (w.st !== got.st)
                begin $display("%0t: status exp %0d got %0d", $time, w.st, got.st); errors++; end
            if (w.width !== got.width)
                begin $display("%0t: width exp %h got %h", $time, w.width, got.width); errors++; end
            if (w.height !== got.height)
                begin $display("%0t: height exp %h got %h", $time, w.height, got.height); errors++; end
            if (w.count !== got.count)
                begin $display("%0t: count exp %h got %h", $time, w.count, got.count); errors++; end
            if (w.ms !== got.ms)
                begin $display("%0t: interval exp %0d got %0d", $time, w.ms, got.ms); errors++; end
        endfunction
    endclass

    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] TAG_STRL = 32'h6C72_7473;
    localparam logic [31:0] TAG_01WB = 32'h6277_3130;
    localparam int IDLE_LIMIT = 20000;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         s_tuser = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [23:0]  cfg_data = 0;

    demux_scoreboard sb = new();
    byte_q_t file_bytes;
    int  hold_cycles = 0;
    bit  calm = 0;
    int  idle_count = 0;
    int  bytes_sent = 0;

    avi_video_chunk_demux u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        demux_res_t got;
        if (m_tvalid && m_tready)
        begin
            got.kind = kind_t'(m_tuser);
            got.pbyte = m_tdata[7:0];
            got.last = m_tlast;
            got.st = m_tdata[10:8];
            got.width = m_tdata[42:11];
            got.height = m_tdata[74:43];
            got.count = m_tdata[106:75];
            got.ms = m_tdata[129:107];
            sb.check_result(got);
        end
        if (s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser, s_tlast);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side stalls
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
            m_tready <= 0;
        else if (hold_cycles > 0)
        begin
            m_tready <= 0;
            hold_cycles--;
        end
        else if (calm || r < 70)
            m_tready <= 1;
        else if (r < 97)
            m_tready <= 0;
        else
        begin
            m_tready <= 0;
            hold_cycles = $urandom_range(10, 60);
        end
    end

    function automatic void put32(ref byte_q_t q, input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_body(ref byte_q_t q, input int n);
        for (int i = 0; i < n + (n & 1); i++)
            q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof);
        int r, gap;
        s_tvalid <= 1;
        s_tdata <= b;
        s_tuser <= sof;
        s_tlast <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        r = $urandom_range(0, 99);
        gap = (calm || r < 75) ? 0 : (r < 97) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_file(input bit keep_sof);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == 0 && keep_sof, i == file_bytes.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.want_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [23:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        sb.capacity = v;
    endtask

    function automatic void build_file();
        byte_q_t hd, mv;
        logic [31:0] t, us, sz;
        int n, nf;
        file_bytes = {};
        t = TAG_RIFF;
        if ($urandom_range(0, 19) == 0)
            t[$urandom_range(0, 31)] ^= 1'b1;
        put32(file_bytes, t);
        put32(file_bytes, $urandom);
        t = TAG_AVI;
        if ($urandom_range(0, 19) == 0)
            t[$urandom_range(0, 31)] ^= 1'b1;
        put32(file_bytes, t);
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(0, 5);
            put32(file_bytes, TAG_JUNK);
            put32(file_bytes, n);
            put_body(file_bytes, n);
        end
        if ($urandom_range(0, 7) != 0)
        begin
            hd = {};
            if ($urandom_range(0, 5) != 0)
            begin
                n = ($urandom_range(0, 1) == 0) ? 56 : $urandom_range(0, 60);
                case ($urandom_range(0, 4))
                    0: us = 0;
                    1: us = 999;
                    2: us = 1000;
                    3: us = 33333;
                    default: us = $urandom;
                endcase
                put32(hd, TAG_AVIH);
                put32(hd, n);
                for (int i = 0; i < n + (n & 1); i++)
                    hd.push_back(i < 4 ? us[8*i +: 8] : 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(0, 7);
                put32(hd, TAG_STRL);
                put32(hd, n);
                put_body(hd, n);
            end
            put32(file_bytes, TAG_LIST);
            put32(file_bytes, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : hd.size() + 4);
            put32(file_bytes, TAG_HDRL);
            file_bytes = {file_bytes, hd};
        end
        if ($urandom_range(0, 7) != 0)
        begin
            mv = {};
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++)
            begin
                case ($urandom_range(0, 4))
                    0, 1: t = TAG_00DC;
                    2, 3: t = TAG_00DB;
                    default: t = TAG_01WB;
                endcase
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
                put32(mv, t);
                put32(mv, sz);
                put_body(mv, sz);
            end
            put32(file_bytes, TAG_LIST);
            sz = mv.size() + 4;
            if ($urandom_range(0, 7) == 0)
                sz = sz - $urandom_range(0, 12) + $urandom_range(0, 12);
            put32(file_bytes, sz);
            put32(file_bytes, TAG_MOVI);
            file_bytes = {file_bytes, mv};
            if ($urandom_range(0, 3) == 0)
                put_body(file_bytes, $urandom_range(1, 6));
        end
        if ($urandom_range(0, 9) == 0)
            file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
    endfunction

    task automatic random_files(input int n_bytes);
        int goal;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal)
        begin
            build_file();
            send_file($urandom_range(0, 19) != 0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // short tag with end of file, bad riff, bad form type, no movi
        file_bytes = {8'h52, 8'h49, 8'h46};
        send_file(1);
        file_bytes = {};
        put32(file_bytes, 32'h5846_4952);
        put32(file_bytes, 32'hFFFF_FFFF);
        send_file(1);
        file_bytes = {};
        put32(file_bytes, TAG_RIFF);
        put32(file_bytes, 0);
        put32(file_bytes, 32'h5849_5641);
        send_file(1);
        file_bytes = {};
        put32(file_bytes, TAG_RIFF);
        put32(file_bytes, 0);
        put32(file_bytes, TAG_AVI);
        send_file(1);
        // short avih, empty frame, odd frame, oversized frame cut by end of file
        file_bytes = {};
        put32(file_bytes, TAG_RIFF);
        put32(file_bytes, 100);
        put32(file_bytes, TAG_AVI);
        put32(file_bytes, TAG_LIST);
        put32(file_bytes, 16);
        put32(file_bytes, TAG_HDRL);
        put32(file_bytes, TAG_AVIH);
        put32(file_bytes, 3);
        put32(file_bytes, 32'h00FF_FFFF);
        put32(file_bytes, TAG_LIST);
        put32(file_bytes, 200);
        put32(file_bytes, TAG_MOVI);
        put32(file_bytes, TAG_00DC);
        put32(file_bytes, 0);
        put32(file_bytes, TAG_00DB);
        put32(file_bytes, 3);
        put32(file_bytes, 32'h00AA_55FF);
        put32(file_bytes, TAG_00DC);
        put32(file_bytes, 32'hFFFF_FFFF);
        send_file(1);
        drain();

        random_files(60);
        drain();
        write_capacity(24'd0);
        random_files(30);
        drain();
        write_capacity(24'hFF_FFFF);
        calm = 1;
        random_files(30);
        drain();
        calm = 0;
        write_capacity(24'd6);
        build_file();
        hold_cycles = 300;
        send_file(1);
        random_files(30);
        drain();
        write_capacity(CAPACITY_RESET);
        random_files(30);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/avcd_pkg.sv
rtl/avi_video_chunk_demux.sv
bench/tb_avi_video_chunk_demux.sv
